// ----- hdl/orbl_pkg.sv -----
// Package with the operation codes, status codes and transaction types of the recency list.
package orbl_pkg;

  localparam int ID_WIDTH    = 6;
  localparam int COUNT_WIDTH = 7;

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_PREPEND    = 3'd1,
    OP_REM_FIRST  = 3'd2,
    OP_REM_LAST   = 3'd3,
    OP_REM_MATCH  = 3'd4,
    OP_MOVE_END   = 3'd5,
    OP_MOVE_FRONT = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MATCH,
    PH_APPLY
  } phase_t;

  typedef struct packed {
    op_t                 operation;
    logic [ID_WIDTH-1:0] block_id;
  } req_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0]    removed_id;
    logic                   found;
    logic                   now_empty;
    logic [COUNT_WIDTH-1:0] entry_count;
    status_t                status;
  } rsp_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic                act;
    op_t                 op;
    logic [ID_WIDTH-1:0] id;
  } cell_cmd_t;

endpackage

// ----- hdl/orbl_cell.sv -----
// One position of the recency list: holds an entry, flags a match and shifts with its neighbors.
module orbl_cell #(
  parameter int MAX_ENTRIES = 64,
  parameter int IDX         = 0
) (
  input  logic                                clk,
  input  orbl_pkg::cell_cmd_t                 cmd,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]    count,
  input  logic                                sel_p,
  input  logic                                lt_p,
  input  logic [orbl_pkg::ID_WIDTH-1:0]       left_entry,
  input  logic [orbl_pkg::ID_WIDTH-1:0]       right_entry,
  output logic [orbl_pkg::ID_WIDTH-1:0]       entry,
  output logic                                match
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] POS      = CW'(IDX);
  localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);

  logic [orbl_pkg::ID_WIDTH-1:0] entry_next;
  logic                          occupied;
  logic                          le_p;

  assign occupied = POS < count;
  assign le_p     = lt_p | sel_p;

  always_comb begin
    entry_next = entry;
    if (cmd.act) begin
      case (cmd.op)
        orbl_pkg::OP_APPEND: begin
          if (POS == count) entry_next = cmd.id;
        end
        orbl_pkg::OP_PREPEND: begin
          if (IDX == 0) entry_next = cmd.id;
          else if (POS <= count) entry_next = left_entry;
        end
        orbl_pkg::OP_REM_FIRST, orbl_pkg::OP_REM_LAST, orbl_pkg::OP_REM_MATCH: begin
          if (!lt_p && POS_NEXT < count) entry_next = right_entry;
        end
        orbl_pkg::OP_MOVE_END: begin
          // The moved entry equals the searched number, so the tail loads the id.
          if (!lt_p && POS_NEXT < count) entry_next = right_entry;
          else if (POS_NEXT == count) entry_next = cmd.id;
        end
        orbl_pkg::OP_MOVE_FRONT: begin
          if (IDX == 0) entry_next = cmd.id;
          else if (le_p) entry_next = left_entry;
        end
        default: entry_next = entry;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    match <= occupied && (entry == cmd.id);
  end

endmodule

// ----- hdl/ordered_block_recency_list_top.sv -----
// Top level of the ordered block recency list: controller, chain of cells and result register.
// A result is registered as the apply phase fires, after the match phase; a stalled result
// holds the apply phase. A new request is accepted when idle or as the previous one fires;
// the match phase registers the per-cell match flags that the shift step needs.
// Reset clears the entry count, the phase and the result valid; list entries are not
// cleared and only the counted ones are ever read.
module ordered_block_recency_list_top #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  orbl_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output orbl_pkg::rsp_t rsp
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = orbl_pkg::ID_WIDTH;

  orbl_pkg::phase_t              phase, phase_next;
  orbl_pkg::op_t                 op_r;
  logic [IW-1:0]                 id_r;
  logic [CW-1:0]                 count, count_next;
  logic [IW-1:0]                 entries [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]        match_vec;
  logic [MAX_ENTRIES-1:0]        onehot, lt_mask, search_oh, last_oh;
  logic [IW-1:0]                 picked;
  logic                          fire, accept, success, full, empty;
  orbl_pkg::cell_cmd_t           cmd;
  orbl_pkg::rsp_t                result;
  logic [CW+orbl_pkg::COUNT_WIDTH-1:0] count_wide;

  assign accept = req_valid && !req_stall;
  assign fire   = (phase == orbl_pkg::PH_APPLY) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= orbl_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    req_stall  = 1'b1;
    case (phase)
      orbl_pkg::PH_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) phase_next = orbl_pkg::PH_MATCH;
      end
      orbl_pkg::PH_MATCH: begin
        phase_next = orbl_pkg::PH_APPLY;
      end
      orbl_pkg::PH_APPLY: begin
        if (fire) begin
          req_stall  = 1'b0;
          phase_next = req_valid ? orbl_pkg::PH_MATCH : orbl_pkg::PH_IDLE;
        end
      end
      default: phase_next = orbl_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= req.operation;
      id_r <= req.block_id;
    end
  end

  assign full  = count == CW'(MAX_ENTRIES);
  assign empty = count == '0;

  // Front-most match: isolate the lowest set flag.
  assign search_oh = match_vec & (~match_vec + MAX_ENTRIES'(1));

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      last_oh[i] = CW'(i) == (count - CW'(1));
    end
  end

  always_comb begin
    case (op_r)
      orbl_pkg::OP_REM_FIRST: onehot = MAX_ENTRIES'(1);
      orbl_pkg::OP_REM_LAST:  onehot = last_oh;
      orbl_pkg::OP_REM_MATCH, orbl_pkg::OP_MOVE_END, orbl_pkg::OP_MOVE_FRONT:
        onehot = search_oh;
      default: onehot = '0;
    endcase
  end

  assign lt_mask = onehot - MAX_ENTRIES'(1);

  always_comb begin
    picked = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      picked = picked | (entries[i] & {IW{onehot[i]}});
    end
  end

  always_comb begin
    success       = 1'b0;
    count_next    = count;
    result        = '0;
    result.status = orbl_pkg::ST_DONE;
    case (op_r)
      orbl_pkg::OP_APPEND, orbl_pkg::OP_PREPEND: begin
        success = !full;
        if (full) result.status = orbl_pkg::ST_FULL;
        else count_next = count + CW'(1);
      end
      orbl_pkg::OP_REM_FIRST, orbl_pkg::OP_REM_LAST: begin
        success = !empty;
        if (empty) begin
          result.status = orbl_pkg::ST_MISSING;
        end else begin
          count_next        = count - CW'(1);
          result.removed_id = picked;
          result.found      = 1'b1;
        end
      end
      orbl_pkg::OP_REM_MATCH, orbl_pkg::OP_MOVE_END, orbl_pkg::OP_MOVE_FRONT: begin
        success = |match_vec;
        if (!success) begin
          result.status = orbl_pkg::ST_MISSING;
        end else begin
          if (op_r == orbl_pkg::OP_REM_MATCH) count_next = count - CW'(1);
          result.removed_id = id_r;
          result.found      = 1'b1;
        end
      end
      orbl_pkg::OP_CLEAR: begin
        success    = 1'b1;
        count_next = '0;
      end
      default: success = 1'b0;
    endcase
    count_wide         = {{orbl_pkg::COUNT_WIDTH{1'b0}}, count_next};
    result.entry_count = count_wide[orbl_pkg::COUNT_WIDTH-1:0];
    result.now_empty   = count_next == '0;
  end

  assign cmd.act = fire && success;
  assign cmd.op  = op_r;
  assign cmd.id  = id_r;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [IW-1:0] left_e, right_e;
    if (g == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid_l
      assign left_e = entries[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_mid_r
      assign right_e = entries[g+1];
    end
    orbl_cell #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .IDX        (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .sel_p      (onehot[g]),
      .lt_p       (lt_mask[g]),
      .left_entry (left_e),
      .right_entry(right_e),
      .entry      (entries[g]),
      .match      (match_vec[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) rsp <= result;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_accept_to_match: assert property (@(posedge clk) disable iff (rst)
    accept |=> phase == orbl_pkg::PH_MATCH)
    else $error("accepted transaction did not enter the match phase");

  a_result_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(phase) == orbl_pkg::PH_APPLY)
    else $error("result appeared outside the apply phase");

  a_refused_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (fire && !success) |=> $stable(count))
    else $error("refused or missed operation changed the count");

endmodule
